// ----- hdl/cir_pkg.sv -----
// Shared types, widths and register constants of the contact impulse resolver.
`timescale 1ns / 1ps
`default_nettype none

package cir_pkg;

  localparam int NUM_STAGES = 30;

  localparam logic [0:0] REG_PERCENT = 1'b0;
  localparam logic [0:0] REG_SLOP    = 1'b1;

  localparam logic [16:0] PERCENT_RESET = 17'd6554;
  localparam logic [30:0] SLOP_RESET    = 31'd3277;
  localparam logic [16:0] ONE_Q16       = 17'd65536;

  // Pipeline stages that do work on the item.
  localparam int ST_PROD  = 1;
  localparam int ST_VN    = 2;
  localparam int ST_SCALE = 3;
  localparam int DIV_LAST = 25;
  localparam int ST_RB    = 26;
  localparam int ST_PART  = 27;
  localparam int ST_SHARE = 28;
  localparam int ST_ALONG = 29;

  typedef struct packed {
    logic [16:0] percent;
    logic [30:0] slop;
  } cfg_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        ima;
    logic [30:0]        imb;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        sum;
    logic [16:0]        e;
    logic [16:0]        pct;
    logic [30:0]        d;
    logic signed [48:0] px;
    logic signed [48:0] py;
    logic [47:0]        dq;
    logic [35:0]        m;
    logic               apply;
    logic               fault;
    logic [36:0]        s;
    logic [31:0]        rem;
    logic [24:0]        qa;
    logic [24:0]        qb;
    logic [43:0]        pa_lo;
    logic [42:0]        pa_hi;
    logic [43:0]        pb_lo;
    logic [42:0]        pb_hi;
    logic [36:0]        ka;
    logic [36:0]        kb;
    logic [52:0]        mxa;
    logic [52:0]        mya;
    logic [52:0]        mxb;
    logic [52:0]        myb;
  } pipe_t;

endpackage

`default_nettype wire

// ----- hdl/cir_cfg.sv -----
// APB-style configuration registers of the contact impulse resolver.
`timescale 1ns / 1ps
`default_nettype none

module cir_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output cir_pkg::cfg_t      cfg
);

  cir_pkg::cfg_t cfg_r;
  cir_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[2])
        cir_pkg::REG_PERCENT: cfg_nxt.percent = pwdata[16:0];
        cir_pkg::REG_SLOP:    cfg_nxt.slop    = pwdata[30:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.percent <= cir_pkg::PERCENT_RESET;
      cfg_r.slop    <= cir_pkg::SLOP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (paddr[2])
      cir_pkg::REG_PERCENT: prdata = {15'd0, cfg_r.percent};
      cir_pkg::REG_SLOP:    prdata = {1'b0, cfg_r.slop};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/contact_impulse_resolver_top.sv -----
// Top level of the contact impulse resolver: a 30-stage pipeline with an output register.
// Throughput is one item per cycle while out_ready does not hold the output; the 25 stages of the
// one-bit-per-stage restoring divider for the mass ratio set the depth. Each stage
// advances on its own, so bubbles collapse and an item is taken while a finished result
// waits. Reset clears all valid bits and loads the register defaults (percent 0.1, slop 0.05).
`timescale 1ns / 1ps
`default_nettype none

module contact_impulse_resolver_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  input  wire logic signed [31:0] in_a_x,
  input  wire logic signed [31:0] in_a_y,
  input  wire logic signed [31:0] in_b_x,
  input  wire logic signed [31:0] in_b_y,
  input  wire logic [30:0]        in_a_inv_mass,
  input  wire logic [30:0]        in_b_inv_mass,
  input  wire logic [16:0]        in_a_restitution,
  input  wire logic [16:0]        in_b_restitution,
  input  wire logic signed [15:0] in_normal_x,
  input  wire logic signed [15:0] in_normal_y,
  input  wire logic [30:0]        in_penetration,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_new_a_x,
  output logic signed [31:0]      out_new_a_y,
  output logic signed [31:0]      out_new_b_x,
  output logic signed [31:0]      out_new_b_y,
  output logic                    out_was_applied,
  output logic                    out_zero_mass_fault,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int NST = cir_pkg::NUM_STAGES;

  cir_pkg::cfg_t  cfg;
  cir_pkg::pipe_t pipe_r   [NST];
  cir_pkg::pipe_t pipe_nxt [NST];
  logic [NST-1:0] valid_r;
  logic [NST-1:0] stage_en;
  logic           out_en;

  logic               out_valid_r;
  logic signed [31:0] new_ax_r, new_ay_r, new_bx_r, new_by_r;
  logic               applied_r, fault_r;
  logic signed [31:0] new_ax_nxt, new_ay_nxt, new_bx_nxt, new_by_nxt;
  logic               applied_nxt;

  cir_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A stage loads when it is empty or when the stage after it also moves.
  always_comb begin
    out_en = !out_valid_r || out_ready;
    stage_en[NST-1] = !valid_r[NST-1] || out_en;
    for (int k = NST - 2; k >= 0; k--) begin
      stage_en[k] = !valid_r[k] || stage_en[k+1];
    end
  end

  assign in_ready = stage_en[0];

  // Saturate a 41-bit signed value into the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -41'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // Move one body along the normal by (k * |n|) >> 14 with the sign of n, or against it when sub is set.
  function automatic logic signed [31:0] move(input logic signed [31:0] p,
                                              input logic [52:0] prod,
                                              input logic neg_n,
                                              input logic sub);
    logic signed [40:0] step;
    logic signed [40:0] val;
    step = $signed({2'b00, prod[52:14]});
    if (neg_n ^ sub) begin
      val = 41'(p) - step;
    end else begin
      val = 41'(p) + step;
    end
    move = sat32(val);
  endfunction

  always_comb begin
    logic [16:0]        e_min;
    logic signed [49:0] vn;
    logic signed [49:0] nvn;
    logic [53:0]        mv;
    logic [32:0]        r2;
    logic [25:0]        qb_w;
    logic [62:0]        tot_a;
    logic [62:0]        tot_b;
    logic [15:0]        mag_x;
    logic [15:0]        mag_y;

    // Stage 0 captures the item, forms the differences and clamps the coefficients.
    pipe_nxt[0]      = pipe_r[0];
    pipe_nxt[0].mode = in_req_type;
    pipe_nxt[0].ax   = in_a_x;
    pipe_nxt[0].ay   = in_a_y;
    pipe_nxt[0].bx   = in_b_x;
    pipe_nxt[0].by   = in_b_y;
    pipe_nxt[0].ima  = in_a_inv_mass;
    pipe_nxt[0].imb  = in_b_inv_mass;
    pipe_nxt[0].nx   = in_normal_x;
    pipe_nxt[0].ny   = in_normal_y;
    pipe_nxt[0].dx   = 33'(in_b_x) - 33'(in_a_x);
    pipe_nxt[0].dy   = 33'(in_b_y) - 33'(in_a_y);
    pipe_nxt[0].sum  = 32'(in_a_inv_mass) + 32'(in_b_inv_mass);
    e_min = (in_a_restitution < in_b_restitution) ? in_a_restitution : in_b_restitution;
    pipe_nxt[0].e    = (e_min > cir_pkg::ONE_Q16) ? cir_pkg::ONE_Q16 : e_min;
    pipe_nxt[0].pct  = (cfg.percent > cir_pkg::ONE_Q16) ? cir_pkg::ONE_Q16 : cfg.percent;
    pipe_nxt[0].d    = (in_penetration > cfg.slop) ? (in_penetration - cfg.slop) : 31'd0;

    for (int k = 1; k < NST; k++) begin
      pipe_nxt[k] = pipe_r[k-1];

      if (k == cir_pkg::ST_PROD) begin
        // Normal products, the position-mode scale and the first quotient bit.
        pipe_nxt[k].px = pipe_r[k-1].dx * pipe_r[k-1].nx;
        pipe_nxt[k].py = pipe_r[k-1].dy * pipe_r[k-1].ny;
        pipe_nxt[k].dq = 48'(pipe_r[k-1].d) * 48'(pipe_r[k-1].pct);
        if (32'(pipe_r[k-1].ima) >= pipe_r[k-1].sum) begin
          pipe_nxt[k].rem = 32'(pipe_r[k-1].ima) - pipe_r[k-1].sum;
          pipe_nxt[k].qa  = 25'd1;
        end else begin
          pipe_nxt[k].rem = 32'(pipe_r[k-1].ima);
          pipe_nxt[k].qa  = 25'd0;
        end
      end

      if (k >= cir_pkg::ST_VN && k <= cir_pkg::DIV_LAST) begin
        // One restoring division step for the Q1.24 share of body A.
        r2 = {pipe_r[k-1].rem, 1'b0};
        if (r2 >= {1'b0, pipe_r[k-1].sum}) begin
          pipe_nxt[k].rem = 32'(r2 - {1'b0, pipe_r[k-1].sum});
          pipe_nxt[k].qa  = {pipe_r[k-1].qa[23:0], 1'b1};
        end else begin
          pipe_nxt[k].rem = r2[31:0];
          pipe_nxt[k].qa  = {pipe_r[k-1].qa[23:0], 1'b0};
        end
      end

      if (k == cir_pkg::ST_VN) begin
        vn  = 50'(pipe_r[k-1].px) + 50'(pipe_r[k-1].py);
        nvn = -vn;
        pipe_nxt[k].m = nvn[49:14];
        if (pipe_r[k-1].mode) begin
          pipe_nxt[k].apply = (pipe_r[k-1].sum != 32'd0);
          pipe_nxt[k].fault = (pipe_r[k-1].sum == 32'd0);
        end else begin
          pipe_nxt[k].apply = (pipe_r[k-1].ima != 31'd0) && (pipe_r[k-1].imb != 31'd0) &&
                              (vn <= 50'sd0);
          pipe_nxt[k].fault = 1'b0;
        end
      end

      if (k == cir_pkg::ST_SCALE) begin
        // Total correction magnitude; zero when nothing is applied.
        mv = 54'(pipe_r[k-1].m) * 54'(18'(cir_pkg::ONE_Q16) + 18'(pipe_r[k-1].e));
        if (!pipe_r[k-1].apply) begin
          pipe_nxt[k].s = 37'd0;
        end else if (pipe_r[k-1].mode) begin
          pipe_nxt[k].s = {5'd0, pipe_r[k-1].dq[47:16]};
        end else begin
          pipe_nxt[k].s = mv[52:16];
        end
      end

      if (k == cir_pkg::ST_RB) begin
        // Share of body B from the quotient and remainder of body A's share.
        qb_w = 26'(1 << 24) - 26'(pipe_r[k-1].qa) - 26'(pipe_r[k-1].rem != 32'd0);
        pipe_nxt[k].qb = qb_w[24:0];
      end

      if (k == cir_pkg::ST_PART) begin
        pipe_nxt[k].pa_lo = 44'(pipe_r[k-1].s[18:0]) * 44'(pipe_r[k-1].qa);
        pipe_nxt[k].pa_hi = 43'(pipe_r[k-1].s[36:19]) * 43'(pipe_r[k-1].qa);
        pipe_nxt[k].pb_lo = 44'(pipe_r[k-1].s[18:0]) * 44'(pipe_r[k-1].qb);
        pipe_nxt[k].pb_hi = 43'(pipe_r[k-1].s[36:19]) * 43'(pipe_r[k-1].qb);
      end

      if (k == cir_pkg::ST_SHARE) begin
        tot_a = {1'b0, pipe_r[k-1].pa_hi, 19'd0} + 63'(pipe_r[k-1].pa_lo);
        tot_b = {1'b0, pipe_r[k-1].pb_hi, 19'd0} + 63'(pipe_r[k-1].pb_lo);
        pipe_nxt[k].ka = tot_a[60:24];
        pipe_nxt[k].kb = tot_b[60:24];
      end

      if (k == cir_pkg::ST_ALONG) begin
        mag_x = 16'(-pipe_r[k-1].nx);
        mag_y = 16'(-pipe_r[k-1].ny);
        if (!pipe_r[k-1].nx[15]) mag_x = pipe_r[k-1].nx;
        if (!pipe_r[k-1].ny[15]) mag_y = pipe_r[k-1].ny;
        pipe_nxt[k].mxa = 53'(pipe_r[k-1].ka) * 53'(mag_x);
        pipe_nxt[k].mya = 53'(pipe_r[k-1].ka) * 53'(mag_y);
        pipe_nxt[k].mxb = 53'(pipe_r[k-1].kb) * 53'(mag_x);
        pipe_nxt[k].myb = 53'(pipe_r[k-1].kb) * 53'(mag_y);
      end
    end
  end

  // Final stage: apply the moves, saturate and flag any change.
  always_comb begin
    new_ax_nxt = move(pipe_r[NST-1].ax, pipe_r[NST-1].mxa, pipe_r[NST-1].nx[15], 1'b1);
    new_ay_nxt = move(pipe_r[NST-1].ay, pipe_r[NST-1].mya, pipe_r[NST-1].ny[15], 1'b1);
    new_bx_nxt = move(pipe_r[NST-1].bx, pipe_r[NST-1].mxb, pipe_r[NST-1].nx[15], 1'b0);
    new_by_nxt = move(pipe_r[NST-1].by, pipe_r[NST-1].myb, pipe_r[NST-1].ny[15], 1'b0);
    applied_nxt = (new_ax_nxt != pipe_r[NST-1].ax) || (new_ay_nxt != pipe_r[NST-1].ay) ||
                  (new_bx_nxt != pipe_r[NST-1].bx) || (new_by_nxt != pipe_r[NST-1].by);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_en[0]) valid_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (stage_en[k]) valid_r[k] <= valid_r[k-1];
      end
      if (out_en) out_valid_r <= valid_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NST; k++) begin
      if (stage_en[k]) pipe_r[k] <= pipe_nxt[k];
    end
    if (out_en) begin
      new_ax_r  <= new_ax_nxt;
      new_ay_r  <= new_ay_nxt;
      new_bx_r  <= new_bx_nxt;
      new_by_r  <= new_by_nxt;
      applied_r <= applied_nxt;
      fault_r   <= pipe_r[NST-1].fault;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_a_x         = new_ax_r;
  assign out_new_a_y         = new_ay_r;
  assign out_new_b_x         = new_bx_r;
  assign out_new_b_y         = new_by_r;
  assign out_was_applied     = applied_r;
  assign out_zero_mass_fault = fault_r;

endmodule

`default_nettype wire
